// ===== rtl/alu_with_status_flags_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ALU with status flags
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ALU_WITH_STATUS_FLAGS_MACROS_SVH
`define ALU_WITH_STATUS_FLAGS_MACROS_SVH

// Checked only while the block is out of reset.
`define AWSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define AWSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/awsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: package
// Widths, operation and condition codes, and the flag word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awsf_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int OP_WIDTH   = 4;
  localparam int IDX_WIDTH  = 4;
  localparam int CC_WIDTH   = 4;
  localparam int FLAG_WIDTH = 5;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD       = 4'd0,
    OP_ADC       = 4'd1,
    OP_SUB       = 4'd2,
    OP_SBB       = 4'd3,
    OP_AND       = 4'd4,
    OP_OR        = 4'd5,
    OP_XOR       = 4'd6,
    OP_CMP       = 4'd7,
    OP_SHL       = 4'd8,
    OP_ASR       = 4'd9,
    OP_SHR       = 4'd10,
    OP_MUL       = 4'd11,
    OP_BTST      = 4'd12,
    OP_LOADFLAGS = 4'd13,
    OP_NONE      = 4'd14
  } alu_op_t;

  typedef enum logic [CC_WIDTH-1:0] {
    CC_CARRY_CLR = 4'd0,
    CC_CARRY_SET = 4'd1,
    CC_OVF_CLR   = 4'd2,
    CC_OVF_SET   = 4'd3,
    CC_ZERO_CLR  = 4'd4,
    CC_ZERO_SET  = 4'd5,
    CC_NEG_CLR   = 4'd6,
    CC_NEG_SET   = 4'd7,
    CC_TEST_CLR  = 4'd8,
    CC_TEST_SET  = 4'd9,
    CC_GE        = 4'd10,
    CC_LT        = 4'd11,
    CC_GT        = 4'd12,
    CC_LE        = 4'd13,
    CC_LS        = 4'd14,
    CC_ALWAYS    = 4'd15
  } cond_code_t;

  // Bit 0 is carry, bit 4 is test.
  typedef struct packed {
    logic t;
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]   operation;
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
    logic [IDX_WIDTH-1:0]  bit_index;
    logic [CC_WIDTH-1:0]   condition_code;
    logic [FLAG_WIDTH-1:0] flags_in;
  } item_t;

endpackage

// ===== rtl/awsf_in_if.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: input channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface awsf_in_if import awsf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_WIDTH-1:0]   operation;
  logic [DATA_WIDTH-1:0] operand_a;
  logic [DATA_WIDTH-1:0] operand_b;
  logic [IDX_WIDTH-1:0]  bit_index;
  logic [CC_WIDTH-1:0]   condition_code;
  logic [FLAG_WIDTH-1:0] flags_in;

  modport source (
    output valid, operation, operand_a, operand_b, bit_index, condition_code, flags_in,
    input  ready
  );

  modport sink (
    input  valid, operation, operand_a, operand_b, bit_index, condition_code, flags_in,
    output ready
  );
endinterface

// ===== rtl/awsf_out_if.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface awsf_out_if import awsf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_low;
  logic [DATA_WIDTH-1:0] result_high;
  logic [FLAG_WIDTH-1:0] flags_out;
  logic                  condition_met;

  modport source (
    output valid, result_low, result_high, flags_out, condition_met,
    input  ready
  );

  modport sink (
    input  valid, result_low, result_high, flags_out, condition_met,
    output ready
  );
endinterface

// ===== rtl/awsf_cond.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: condition evaluator
// Tests a condition code against a flag word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awsf_cond import awsf_pkg::*; (
  input  logic [CC_WIDTH-1:0] condition_code,
  input  flags_t              flags,
  output logic                condition_met
);

  always_comb begin
    case (condition_code)
      CC_CARRY_CLR: condition_met = !flags.c;
      CC_CARRY_SET: condition_met = flags.c;
      CC_OVF_CLR:   condition_met = !flags.v;
      CC_OVF_SET:   condition_met = flags.v;
      CC_ZERO_CLR:  condition_met = !flags.z;
      CC_ZERO_SET:  condition_met = flags.z;
      CC_NEG_CLR:   condition_met = !flags.n;
      CC_NEG_SET:   condition_met = flags.n;
      CC_TEST_CLR:  condition_met = !flags.t;
      CC_TEST_SET:  condition_met = flags.t;
      CC_GE:        condition_met = (flags.n == flags.v);
      CC_LT:        condition_met = (flags.n != flags.v);
      CC_GT:        condition_met = (flags.n == flags.v) && !flags.z;
      CC_LE:        condition_met = (flags.n != flags.v) || flags.z;
      CC_LS:        condition_met = !flags.c || flags.z;
      default:      condition_met = 1'b1;
    endcase
  end

endmodule

// ===== rtl/awsf_exec.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: execution unit
// Adder, logic unit, shifter, multiplier and flag update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awsf_exec import awsf_pkg::*; (
  input  logic [OP_WIDTH-1:0]   operation,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  input  logic [IDX_WIDTH-1:0]  bit_index,
  input  logic [FLAG_WIDTH-1:0] flags_in,
  input  flags_t                flags_cur,
  output logic [DATA_WIDTH-1:0] result_low,
  output logic [DATA_WIDTH-1:0] result_high,
  output flags_t                flags_new
);

  logic [DATA_WIDTH-1:0]   add_s;
  logic [DATA_WIDTH-1:0]   add_t;
  logic                    add_cin;
  logic [DATA_WIDTH:0]     add_sum;
  logic [DATA_WIDTH-1:0]   add_res;
  flags_t                  add_flags;
  logic [2*DATA_WIDTH-1:0] product;
  logic [DATA_WIDTH-1:0]   logic_res;
  logic [DATA_WIDTH-1:0]   shift_res;

  // Adder operand selection: subtraction adds the complement of operand_b.
  always_comb begin
    add_s   = operand_a;
    add_t   = operand_b;
    add_cin = 1'b0;
    case (operation)
      OP_ADC: begin
        add_cin = flags_cur.c;
      end
      OP_SUB, OP_CMP: begin
        add_t   = ~operand_b;
        add_cin = 1'b1;
      end
      OP_SBB: begin
        add_t   = ~operand_b;
        add_cin = flags_cur.c;
      end
      OP_SHL: begin
        add_t   = operand_a;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_s} + {1'b0, add_t} + {{DATA_WIDTH{1'b0}}, add_cin};
  assign add_res = add_sum[DATA_WIDTH-1:0];

  always_comb begin
    add_flags   = flags_cur;
    add_flags.n = add_res[DATA_WIDTH-1];
    add_flags.z = (add_res == '0);
    add_flags.v = (add_res[DATA_WIDTH-1] ^ add_s[DATA_WIDTH-1])
                  & ~(add_s[DATA_WIDTH-1] ^ add_t[DATA_WIDTH-1]);
    add_flags.c = add_sum[DATA_WIDTH];
  end

  assign product = {{DATA_WIDTH{1'b0}}, operand_a} * {{DATA_WIDTH{1'b0}}, operand_b};

  always_comb begin
    case (operation)
      OP_AND:  logic_res = operand_a & operand_b;
      OP_OR:   logic_res = operand_a | operand_b;
      default: logic_res = operand_a ^ operand_b;
    endcase
  end

  always_comb begin
    if (operation == OP_ASR) begin
      shift_res = {operand_a[DATA_WIDTH-1], operand_a[DATA_WIDTH-1:1]};
    end else begin
      shift_res = {1'b0, operand_a[DATA_WIDTH-1:1]};
    end
  end

  always_comb begin
    result_low  = '0;
    result_high = '0;
    flags_new   = flags_cur;
    case (operation)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_SHL: begin
        result_low = add_res;
        flags_new  = add_flags;
      end
      OP_CMP: begin
        flags_new = add_flags;
      end
      OP_AND, OP_OR, OP_XOR: begin
        result_low  = logic_res;
        flags_new.n = logic_res[DATA_WIDTH-1];
        flags_new.z = (logic_res == '0);
        flags_new.v = 1'b0;
        flags_new.c = 1'b0;
      end
      OP_ASR: begin
        result_low  = shift_res;
        flags_new.n = operand_a[DATA_WIDTH-1];
        flags_new.z = (shift_res == '0);
        flags_new.v = 1'b0;
        flags_new.c = operand_a[0];
      end
      OP_SHR: begin
        // Both carry and overflow take the bit shifted out.
        result_low  = shift_res;
        flags_new.n = 1'b0;
        flags_new.z = (shift_res == '0);
        flags_new.v = operand_a[0];
        flags_new.c = operand_a[0];
      end
      OP_MUL: begin
        result_low  = product[DATA_WIDTH-1:0];
        result_high = product[2*DATA_WIDTH-1:DATA_WIDTH];
      end
      OP_BTST: begin
        flags_new.t = operand_a[bit_index];
      end
      OP_LOADFLAGS: begin
        flags_new = flags_t'(flags_in);
      end
      default: begin
        flags_new = flags_cur;
      end
    endcase
  end

endmodule

// ===== rtl/alu_with_status_flags.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags
// 16-bit ALU with a kept five-flag status word and condition evaluation.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side is not
// stalled and returns one result item for each. An accepted item is held
// in an input register; the adder, logic unit, shifter, 16x16 multiplier
// and condition test then work on it in a single pass into the result
// register. The status flag register is written as an item moves into the
// result register, so the following item sees those flags in the next
// cycle; this flag loop sets the one-item-per-cycle rate.
`timescale 1ns / 1ps
`include "alu_with_status_flags_macros.svh"

module alu_with_status_flags import awsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  awsf_in_if.sink    in_ch,
  awsf_out_if.source out_ch
);

  item_t                 s1_item_r;
  logic                  s1_valid_r;
  logic                  s1_adv;
  flags_t                flags_r;
  flags_t                flags_nxt;
  logic [DATA_WIDTH-1:0] exec_low;
  logic [DATA_WIDTH-1:0] exec_high;
  logic                  exec_met;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_low_r;
  logic [DATA_WIDTH-1:0] out_high_r;
  flags_t                out_flags_r;
  logic                  out_met_r;

  // The held item moves on when the result register is empty or being drained.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.operation      <= in_ch.operation;
      s1_item_r.operand_a      <= in_ch.operand_a;
      s1_item_r.operand_b      <= in_ch.operand_b;
      s1_item_r.bit_index      <= in_ch.bit_index;
      s1_item_r.condition_code <= in_ch.condition_code;
      s1_item_r.flags_in       <= in_ch.flags_in;
    end
  end

  awsf_exec u_exec (
    .operation   (s1_item_r.operation),
    .operand_a   (s1_item_r.operand_a),
    .operand_b   (s1_item_r.operand_b),
    .bit_index   (s1_item_r.bit_index),
    .flags_in    (s1_item_r.flags_in),
    .flags_cur   (flags_r),
    .result_low  (exec_low),
    .result_high (exec_high),
    .flags_new   (flags_nxt)
  );

  awsf_cond u_cond (
    .condition_code (s1_item_r.condition_code),
    .flags          (flags_r),
    .condition_met  (exec_met)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (s1_adv) begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_low_r   <= exec_low;
      out_high_r  <= exec_high;
      out_flags_r <= flags_nxt;
      out_met_r   <= exec_met;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_low    = out_low_r;
  assign out_ch.result_high   = out_high_r;
  assign out_ch.flags_out     = out_flags_r;
  assign out_ch.condition_met = out_met_r;

  `AWSF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")
  `AWSF_ASSERT(a_flags_hold, !s1_adv |=> $stable(flags_r), "status flags changed with no item retiring")
  `AWSF_ASSERT(a_out_flags_match, s1_adv |=> out_flags_r == flags_r, "reported flags differ from kept flags")
  `AWSF_ASSERT(a_loadflags, (s1_adv && s1_item_r.operation == OP_LOADFLAGS) |=> flags_r == flags_t'($past(s1_item_r.flags_in)), "flag load not applied")
  `AWSF_ASSERT(a_high_zero, (s1_adv && s1_item_r.operation != OP_MUL) |=> out_high_r == '0, "high word set outside multiply")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// ALU with status flags: testbench
// Drives operation items through the valid/ready input channel and checks
// every result item against a predictor that carries its own copy of the
// status flags. A directed run covers the operand extremes and every
// operation. Three random runs follow, each with a different idling mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import awsf_pkg::*;;

  // The one operation code the package leaves unnamed; the block treats it
  // as no operation.
  localparam logic [OP_WIDTH-1:0] OP_UNUSED = 4'd15;
  localparam int RANDOM_PER_PHASE = 344;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result_low;
    logic [DATA_WIDTH-1:0] result_high;
    flags_t                flags_out;
    logic                  condition_met;
  } alu_result_t;

  logic clk;
  logic rst_n;

  awsf_in_if  in_ch ();
  awsf_out_if out_ch ();

  alu_with_status_flags u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  item_t       pending_items[$];
  alu_result_t expected_results[$];
  flags_t      flag_model;
  item_t       drive_item;
  item_t       seen_item;
  alu_result_t want;
  logic        in_taken;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count;

  always #1 clk = ~clk;

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = '0;
    in_ch.operand_a      = '0;
    in_ch.operand_b      = '0;
    in_ch.bit_index      = '0;
    in_ch.condition_code = '0;
    in_ch.flags_in       = '0;
    out_ch.ready         = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic condition_holds(logic [CC_WIDTH-1:0] code, flags_t f);
    case (code)
      CC_CARRY_CLR: return !f.c;
      CC_CARRY_SET: return f.c;
      CC_OVF_CLR:   return !f.v;
      CC_OVF_SET:   return f.v;
      CC_ZERO_CLR:  return !f.z;
      CC_ZERO_SET:  return f.z;
      CC_NEG_CLR:   return !f.n;
      CC_NEG_SET:   return f.n;
      CC_TEST_CLR:  return !f.t;
      CC_TEST_SET:  return f.t;
      CC_GE:        return f.n == f.v;
      CC_LT:        return f.n != f.v;
      CC_GT:        return (f.n == f.v) && !f.z;
      CC_LE:        return (f.n != f.v) || f.z;
      CC_LS:        return !f.c || f.z;
      default:      return 1'b1;
    endcase
  endfunction

  // Works out the result of one item and moves the flag copy on.
  function automatic alu_result_t predict_alu(item_t it);
    alu_result_t             r;
    flags_t                  f;
    logic [DATA_WIDTH-1:0]   a;
    logic [DATA_WIDTH-1:0]   addend;
    logic                    carry_in;
    logic                    use_adder;
    logic [DATA_WIDTH:0]     sum;
    logic [2*DATA_WIDTH-1:0] product;
    r         = '0;
    f         = flag_model;
    a         = it.operand_a;
    addend    = it.operand_b;
    carry_in  = 1'b0;
    use_adder = 1'b0;
    r.condition_met = condition_holds(it.condition_code, f);
    case (it.operation)
      OP_ADD: begin
        use_adder = 1'b1;
      end
      OP_ADC: begin
        use_adder = 1'b1;
        carry_in  = f.c;
      end
      OP_SUB, OP_CMP: begin
        use_adder = 1'b1;
        addend    = ~it.operand_b;
        carry_in  = 1'b1;
      end
      OP_SBB: begin
        use_adder = 1'b1;
        addend    = ~it.operand_b;
        carry_in  = f.c;
      end
      OP_SHL: begin
        use_adder = 1'b1;
        addend    = a;
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (it.operation == OP_AND) r.result_low = a & it.operand_b;
        else if (it.operation == OP_OR) r.result_low = a | it.operand_b;
        else r.result_low = a ^ it.operand_b;
        f.c = 1'b0;
        f.v = 1'b0;
        f.n = r.result_low[DATA_WIDTH-1];
        f.z = (r.result_low == '0);
      end
      OP_ASR: begin
        r.result_low = {a[DATA_WIDTH-1], a[DATA_WIDTH-1:1]};
        f.n = a[DATA_WIDTH-1];
        f.z = (r.result_low == '0);
        f.c = a[0];
        f.v = 1'b0;
      end
      OP_SHR: begin
        // Carry and overflow both take the bit shifted out.
        r.result_low = {1'b0, a[DATA_WIDTH-1:1]};
        f.n = 1'b0;
        f.z = (r.result_low == '0);
        f.c = a[0];
        f.v = a[0];
      end
      OP_MUL: begin
        product       = {{DATA_WIDTH{1'b0}}, a} * {{DATA_WIDTH{1'b0}}, it.operand_b};
        r.result_low  = product[DATA_WIDTH-1:0];
        r.result_high = product[2*DATA_WIDTH-1:DATA_WIDTH];
      end
      OP_BTST: begin
        f.t = a[it.bit_index];
      end
      OP_LOADFLAGS: begin
        f = flags_t'(it.flags_in);
      end
      default: ;
    endcase
    if (use_adder) begin
      sum = {1'b0, a} + {1'b0, addend} + {{DATA_WIDTH{1'b0}}, carry_in};
      f.n = sum[DATA_WIDTH-1];
      f.z = (sum[DATA_WIDTH-1:0] == '0);
      f.v = (sum[DATA_WIDTH-1] ^ a[DATA_WIDTH-1])
            & ~(a[DATA_WIDTH-1] ^ addend[DATA_WIDTH-1]);
      f.c = sum[DATA_WIDTH];
      if (it.operation != OP_CMP) r.result_low = sum[DATA_WIDTH-1:0];
    end
    flag_model  = f;
    r.flags_out = f;
    return r;
  endfunction

  // Sender: a new item is offered only once the previous one has gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = pending_items.pop_front();
        in_ch.operation      <= drive_item.operation;
        in_ch.operand_a      <= drive_item.operand_a;
        in_ch.operand_b      <= drive_item.operand_b;
        in_ch.bit_index      <= drive_item.bit_index;
        in_ch.condition_code <= drive_item.condition_code;
        in_ch.flags_in       <= drive_item.flags_in;
        in_ch.valid          <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken   <= 1'b0;
      flag_model = '0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_item.operation      = in_ch.operation;
        seen_item.operand_a      = in_ch.operand_a;
        seen_item.operand_b      = in_ch.operand_b;
        seen_item.bit_index      = in_ch.bit_index;
        seen_item.condition_code = in_ch.condition_code;
        seen_item.flags_in       = in_ch.flags_in;
        expected_results.push_back(predict_alu(seen_item));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with none expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_low !== want.result_low) begin
            $error("result_low: expected %h, got %h", want.result_low, out_ch.result_low);
            fail_count++;
          end
          if (out_ch.result_high !== want.result_high) begin
            $error("result_high: expected %h, got %h", want.result_high, out_ch.result_high);
            fail_count++;
          end
          if (out_ch.flags_out !== want.flags_out) begin
            $error("flags_out: expected %b, got %b", want.flags_out, out_ch.flags_out);
            fail_count++;
          end
          if (out_ch.condition_met !== want.condition_met) begin
            $error("condition_met: expected %b, got %b", want.condition_met,
                   out_ch.condition_met);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic item_t make_item(logic [OP_WIDTH-1:0] op, logic [DATA_WIDTH-1:0] a,
                                      logic [DATA_WIDTH-1:0] b, logic [IDX_WIDTH-1:0] idx,
                                      logic [CC_WIDTH-1:0] cc, logic [FLAG_WIDTH-1:0] fin);
    item_t it;
    it.operation      = op;
    it.operand_a      = a;
    it.operand_b      = b;
    it.bit_index      = idx;
    it.condition_code = cc;
    it.flags_in       = fin;
    return it;
  endfunction

  // Operands lean towards the values where carry and overflow change.
  function automatic logic [DATA_WIDTH-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h7fff;
      4:       return 16'h0001;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    logic [OP_WIDTH-1:0] op;
    if ($urandom_range(49) == 0) op = OP_UNUSED;
    else op = OP_WIDTH'($urandom_range(int'(OP_NONE)));
    return make_item(op, random_word(), random_word(), IDX_WIDTH'($urandom_range(15)),
                     CC_WIDTH'($urandom_range(15)), FLAG_WIDTH'($urandom_range(31)));
  endfunction

  // Waits until every pending item has been sent and every expected result has been returned.
  task automatic wait_drained();
    while (pending_items.size() != 0 || (in_ch.valid && !in_taken) ||
           expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_PER_PHASE) pending_items.push_back(random_item());
    wait_drained();
  endtask

  initial begin
    fail_count    = 0;
    send_idle_pct = 18;
    recv_idle_pct = 55;
    @(posedge rst_n);
    pending_items.push_back(make_item(OP_LOADFLAGS, 16'h0000, 16'h0000, 4'd0, CC_ALWAYS, 5'h1f));
    pending_items.push_back(make_item(OP_ADD, 16'hffff, 16'h0001, 4'd0, CC_CARRY_SET, 5'h00));
    pending_items.push_back(make_item(OP_ADC, 16'h7fff, 16'h0000, 4'd0, CC_CARRY_CLR, 5'h00));
    pending_items.push_back(make_item(OP_SUB, 16'h8000, 16'h0001, 4'd0, CC_OVF_SET, 5'h00));
    pending_items.push_back(make_item(OP_SBB, 16'h0000, 16'hffff, 4'd0, CC_OVF_CLR, 5'h00));
    pending_items.push_back(make_item(OP_AND, 16'hffff, 16'h8000, 4'd0, CC_ZERO_CLR, 5'h00));
    pending_items.push_back(make_item(OP_OR, 16'h0000, 16'h0000, 4'd0, CC_ZERO_SET, 5'h00));
    pending_items.push_back(make_item(OP_XOR, 16'hffff, 16'hffff, 4'd0, CC_NEG_CLR, 5'h00));
    pending_items.push_back(make_item(OP_CMP, 16'h0005, 16'h0005, 4'd0, CC_NEG_SET, 5'h00));
    pending_items.push_back(make_item(OP_SHL, 16'h8000, 16'h0000, 4'd0, CC_TEST_CLR, 5'h00));
    pending_items.push_back(make_item(OP_ASR, 16'h8001, 16'h0000, 4'd0, CC_TEST_SET, 5'h00));
    pending_items.push_back(make_item(OP_SHR, 16'h0001, 16'h0000, 4'd0, CC_GE, 5'h00));
    pending_items.push_back(make_item(OP_MUL, 16'hffff, 16'hffff, 4'd0, CC_LT, 5'h00));
    pending_items.push_back(make_item(OP_BTST, 16'h8000, 16'h0000, 4'd15, CC_GT, 5'h00));
    pending_items.push_back(make_item(OP_BTST, 16'hfffe, 16'h0000, 4'd0, CC_LE, 5'h00));
    pending_items.push_back(make_item(OP_LOADFLAGS, 16'h0000, 16'h0000, 4'd0, CC_LS, 5'h00));
    pending_items.push_back(make_item(OP_NONE, 16'hffff, 16'hffff, 4'd15, CC_ALWAYS, 5'h1f));
    pending_items.push_back(make_item(OP_UNUSED, 16'hffff, 16'hffff, 4'd15, CC_LS, 5'h1f));
    pending_items.push_back(make_item(OP_MUL, 16'h0000, 16'hffff, 4'd0, CC_CARRY_CLR, 5'h00));
    pending_items.push_back(make_item(OP_SUB, 16'h0000, 16'h0000, 4'd0, CC_ALWAYS, 5'h00));
    wait_drained();
    run_random(18, 55);
    run_random(55, 18);
    run_random(0, 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("alu_with_status_flags: match");
    end else begin
      $display("alu_with_status_flags: mismatch");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("alu_with_status_flags: mismatch");
    $finish;
  end

endmodule
